// ===== hdl/bsnm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the byte stream needle matcher.
package bsnm_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_NEEDLE_DEFAULT    = 8;
  localparam int POSITION_BITS_DEFAULT = 32;

  // Fixed field widths.
  localparam int BYTE_BITS      = 8;
  localparam int NEEDLE_BITS    = 64;
  localparam int NEEDLE_SLOTS   = NEEDLE_BITS / BYTE_BITS;
  localparam int SLOT_BITS      = $clog2(NEEDLE_SLOTS);
  localparam int LENGTH_BITS    = 4;
  localparam int OUT_BITS       = 32;
  localparam int RESULT_BITS    = 3 * OUT_BITS;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [BYTE_BITS-1:0] NEWLINE_CHAR = 8'h0A;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_NEEDLE_BYTES  = 2'd0,
    REG_NEEDLE_LENGTH = 2'd1
  } cfg_reg_t;

  // One result word; the last field sits in the lowest bits.
  typedef struct packed {
    logic [OUT_BITS-1:0] column;
    logic [OUT_BITS-1:0] line_number;
    logic [OUT_BITS-1:0] match_offset;
  } result_t;

endpackage

// ===== hdl/bsnm_match.sv =====
`timescale 1ns / 1ps
// Parallel needle compare against the shifted byte window.
module bsnm_match #(
  parameter int MAX_NEEDLE = bsnm_pkg::MAX_NEEDLE_DEFAULT,
  parameter int LEN_W      = $clog2(MAX_NEEDLE + 1)
) (
  input  logic [MAX_NEEDLE-1:0][bsnm_pkg::BYTE_BITS-1:0] window_chars,
  input  logic [bsnm_pkg::NEEDLE_BITS-1:0]               needle_bytes,
  input  logic [LEN_W-1:0]                               match_len,
  input  logic [LEN_W-1:0]                               fresh,
  output logic                                           hit
);
  import bsnm_pkg::*;

  // Window entry j (newest at 0) must equal needle byte len-1-j.
  always_comb begin
    logic [LEN_W-1:0]     diff;
    logic [SLOT_BITS-1:0] sel;
    hit  = (fresh >= match_len);
    diff = '0;
    sel  = '0;
    for (int j = 0; j < MAX_NEEDLE; j++) begin
      if (LEN_W'(j) < match_len) begin
        diff = match_len - LEN_W'(j + 1);
        sel  = SLOT_BITS'(diff);
        if (window_chars[j] != needle_bytes[BYTE_BITS*sel +: BYTE_BITS]) begin
          hit = 1'b0;
        end
      end
    end
  end

endmodule

// ===== hdl/byte_stream_needle_matcher.sv =====
`timescale 1ns / 1ps
// Top level of the byte stream needle matcher.
//
// The block scans a file presented one byte per word on the input stream and reports the
// leftmost non-overlapping exact occurrences of a needle of 1 to MAX_NEEDLE bytes. Each match
// yields one output word holding the byte offset of the match's first byte, its 0-based line
// number and its column within that line; a line ends with, and includes, its newline byte.
// A match is detected on its final byte, in the same cycle as that byte is accepted, and the
// result word is registered. The block takes one byte per cycle unless stalled: all the work
// for a byte is the window shift, the parallel compare and the counter increments, done in a
// single pass between the state registers and the result register. A two-word result buffer
// (result register plus skid stage) lets input continue while a result waits; input stalls
// only when both hold a word. The offset, line and column counters saturate at
// 2^POSITION_BITS - 1 and their low 32 bits are reported. Setting tlast on a byte restarts all
// counters after that byte, so no match spans two files. The needle and its length are set
// through the configuration channel, which is always ready, and should be written only while
// the block is idle. A length of zero acts as one and a length above MAX_NEEDLE as MAX_NEEDLE.
module byte_stream_needle_matcher #(
  parameter int MAX_NEEDLE    = bsnm_pkg::MAX_NEEDLE_DEFAULT,
  parameter int POSITION_BITS = bsnm_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [bsnm_pkg::BYTE_BITS-1:0]        s_tdata,   // data_byte
  input  logic                                  s_tlast,   // last_byte
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [bsnm_pkg::RESULT_BITS-1:0]      m_tdata,   // match_offset, line_number, column
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bsnm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [bsnm_pkg::NEEDLE_BITS-1:0]      cfg_data
);
  import bsnm_pkg::*;

  localparam int LEN_W = $clog2(MAX_NEEDLE + 1);
  localparam int IDX_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
  localparam logic [POSITION_BITS-1:0] COUNT_MAX = {POSITION_BITS{1'b1}};

  // Configuration registers.
  logic [NEEDLE_BITS-1:0] needle_bytes;
  logic [LENGTH_BITS-1:0] needle_length;

  // Byte window, newest entry at index 0, with the line and column each byte arrived at.
  logic [MAX_NEEDLE-1:0][BYTE_BITS-1:0] window_chars;
  logic [MAX_NEEDLE-1:0][BYTE_BITS-1:0] shifted_chars;
  logic [POSITION_BITS-1:0]             window_lines   [MAX_NEEDLE];
  logic [POSITION_BITS-1:0]             window_columns [MAX_NEEDLE];
  logic [POSITION_BITS-1:0]             shifted_lines  [MAX_NEEDLE];
  logic [POSITION_BITS-1:0]             shifted_columns[MAX_NEEDLE];

  // Running counters for the next byte.
  logic [POSITION_BITS-1:0] byte_position;
  logic [POSITION_BITS-1:0] current_line;
  logic [POSITION_BITS-1:0] current_column;
  logic [LEN_W-1:0]         fresh_bytes;

  logic [LEN_W-1:0]         len;
  logic [LEN_W-1:0]         len_minus1;
  logic [IDX_W-1:0]         start_idx;
  logic [LEN_W-1:0]         fresh_inc;
  logic [POSITION_BITS-1:0] start_offset;
  logic                     hit;
  logic                     accept;
  logic                     is_newline;
  result_t                  new_result;

  // Two-word result buffer.
  logic    out_valid;
  result_t out_result;
  logic    skid_valid;
  result_t skid_result;
  logic    pop;
  logic    push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_bytes  <= '0;
      needle_length <= LENGTH_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NEEDLE_BYTES:  needle_bytes  <= cfg_data;
        REG_NEEDLE_LENGTH: needle_length <= cfg_data[LENGTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Length in use, clamped to the range the window supports.
  always_comb begin
    if (needle_length == '0) begin
      len = LEN_W'(1);
    end else if (needle_length > LENGTH_BITS'(MAX_NEEDLE)) begin
      len = LEN_W'(MAX_NEEDLE);
    end else begin
      len = LEN_W'(needle_length);
    end
  end

  assign len_minus1 = len - LEN_W'(1);
  assign start_idx  = IDX_W'(len_minus1);

  // The window as it stands once the incoming byte has been shifted in.
  always_comb begin
    shifted_chars[0]   = s_tdata;
    shifted_lines[0]   = current_line;
    shifted_columns[0] = current_column;
    for (int i = 1; i < MAX_NEEDLE; i++) begin
      shifted_chars[i]   = window_chars[i-1];
      shifted_lines[i]   = window_lines[i-1];
      shifted_columns[i] = window_columns[i-1];
    end
  end

  assign fresh_inc = (fresh_bytes < LEN_W'(MAX_NEEDLE)) ? fresh_bytes + LEN_W'(1) : fresh_bytes;

  bsnm_match #(
    .MAX_NEEDLE (MAX_NEEDLE),
    .LEN_W      (LEN_W)
  ) u_match (
    .window_chars (shifted_chars),
    .needle_bytes (needle_bytes),
    .match_len    (len),
    .fresh        (fresh_inc),
    .hit          (hit)
  );

  // The match starts len-1 bytes before the current one.
  assign start_offset = byte_position - POSITION_BITS'(len_minus1);

  always_comb begin
    new_result.match_offset = OUT_BITS'(start_offset);
    new_result.line_number  = OUT_BITS'(shifted_lines[start_idx]);
    new_result.column       = OUT_BITS'(shifted_columns[start_idx]);
  end

  assign accept     = s_tvalid && s_tready;
  assign is_newline = (s_tdata == NEWLINE_CHAR);

  // Window contents are only read once fresh_bytes vouches for them, so they carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      window_chars <= shifted_chars;
      for (int i = 0; i < MAX_NEEDLE; i++) begin
        window_lines[i]   <= shifted_lines[i];
        window_columns[i] <= shifted_columns[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      current_line   <= '0;
      current_column <= '0;
      fresh_bytes    <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        byte_position  <= '0;
        current_line   <= '0;
        current_column <= '0;
        fresh_bytes    <= '0;
      end else begin
        byte_position <= (byte_position == COUNT_MAX) ? byte_position
                                                      : byte_position + POSITION_BITS'(1);
        if (is_newline) begin
          current_line   <= (current_line == COUNT_MAX) ? current_line
                                                        : current_line + POSITION_BITS'(1);
          current_column <= '0;
        end else begin
          current_column <= (current_column == COUNT_MAX) ? current_column
                                                          : current_column + POSITION_BITS'(1);
        end
        fresh_bytes <= hit ? '0 : fresh_inc;
      end
    end
  end

  // Result buffer: the skid stage only fills when the result register is stalled.
  assign pop  = out_valid && m_tready;
  assign push = accept && hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_result <= skid_result;
        if (push) begin
          skid_result <= new_result;
        end
      end else if (push) begin
        out_result <= new_result;
      end
    end else if (!out_valid) begin
      if (push) begin
        out_result <= new_result;
      end
    end else if (push) begin
      skid_result <= new_result;
    end
  end

  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_result;

endmodule

// ===== hdl/bsnm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the byte stream needle matcher and their binding.
module bsnm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [bsnm_pkg::RESULT_BITS-1:0]    m_tdata,
  input logic                                cfg_valid,
  input logic                                cfg_ready
);

  // A stalled result word keeps its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // A new result only follows an accepted byte.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !$past(m_tvalid) && !$past(rst) |-> $past(s_tvalid && s_tready))
    else $error("result word without an accepted byte");

  // Input is only held off while results are waiting.
  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

  // The configuration channel never stalls.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind byte_stream_needle_matcher bsnm_checker u_bsnm_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
